[rtl/saw_pkg.sv]
// Shared types and constants for the stop-and-wait ARQ controller.
// No dependencies; the controller and the testbench import this package.
package saw_pkg;

   // Event codes on the request channel; the fourth code is unused.
   typedef enum logic [1:0] {
      OP_SEND  = 2'd0,
      OP_FRAME = 2'd1,
      OP_TIMER = 2'd2
   } op_type;

   // What goes out on the link.
   typedef enum logic [1:0] {
      TX_NONE = 2'd0,
      TX_DATA = 2'd1,
      TX_RTX  = 2'd2,
      TX_ACK  = 2'd3
   } tx_kind_type;

   // Timer commands.
   typedef enum logic [1:0] {
      TM_KEEP    = 2'd0,
      TM_ACK     = 2'd1,
      TM_BACKOFF = 2'd2,
      TM_STOP    = 2'd3
   } timer_cmd_type;

   // Protocol phase codes as seen on the response channel.
   localparam logic [1:0] PHASE_IDLE     = 2'd0;
   localparam logic [1:0] PHASE_WAIT     = 2'd1;
   localparam logic [1:0] PHASE_BACK_ACK = 2'd2;
   localparam logic [1:0] PHASE_BACK_RTX = 2'd3;

   // Control byte layout and encodings.
   localparam int unsigned CTRL_ACK_BIT = 7;
   localparam int unsigned CTRL_SEQ_BIT = 3;
   localparam logic [7:0]  CTRL_DATA0   = 8'h00;
   localparam logic [7:0]  CTRL_DATA1   = 8'h08;
   localparam logic [7:0]  CTRL_ACK0    = 8'h80;
   localparam logic [7:0]  CTRL_ACK1    = 8'h88;

   localparam logic [3:0]  MAX_RETRIES_RESET = 4'd3;

   // Control byte for a data frame with the given sequence bit.
   function automatic logic [7:0] data_ctrl(input logic seq);
      return seq ? CTRL_DATA1 : CTRL_DATA0;
   endfunction

   // Control byte for an ack frame with the given sequence bit.
   function automatic logic [7:0] ack_ctrl(input logic seq);
      return seq ? CTRL_ACK1 : CTRL_ACK0;
   endfunction

endpackage

[rtl/saw_req_if.sv]
// Request channel of the stop-and-wait ARQ controller: one event per request.
// Depends on nothing; widths match the fields in saw_pkg usage.
interface saw_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] frame_ctrl;

   modport source (output valid, operation, frame_ctrl, input ready);
   modport sink   (input valid, operation, frame_ctrl, output ready);
endinterface

[rtl/saw_rsp_if.sv]
// Response channel of the stop-and-wait ARQ controller: one result per request.
// Depends on nothing.
interface saw_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] tx_kind;
   logic [7:0] tx_ctrl;
   logic       deliver_up;
   logic       give_up;
   logic [1:0] timer_cmd;
   logic       request_refused;
   logic [1:0] phase_now;

   modport source (output valid, tx_kind, tx_ctrl, deliver_up, give_up, timer_cmd,
                   request_refused, phase_now, input ready);
   modport sink   (input valid, tx_kind, tx_ctrl, deliver_up, give_up, timer_cmd,
                   request_refused, phase_now, output ready);
endinterface

[rtl/stop_and_wait_arq_fsm.sv]
// Stop-and-wait ARQ control FSM (one-bit sequence numbers); uses saw_pkg and the channel ifs.
// Response valid is registered: it rises in the cycle after a request is accepted.
// Throughput: one request per cycle; a request is taken whenever the response
// register is empty or is being drained in the same cycle.
// Reset (synchronous, active high): idle phase, both sequence bits and retry
// count zero, max_retries 3, response register empty.
module stop_and_wait_arq_fsm (
   input  logic            clock,
   input  logic            reset,
   saw_req_if.sink         req_chan,
   saw_rsp_if.source       rsp_chan,
   input  logic            csr_wr_en,
   input  logic [3:0]      csr_wr_data
);
   import saw_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE     = PHASE_IDLE,
      ST_WAIT     = PHASE_WAIT,
      ST_BACK_ACK = PHASE_BACK_ACK,
      ST_BACK_RTX = PHASE_BACK_RTX
   } phase_type;

   // Protocol state
   phase_type     phase_ff, phase_in;
   logic          send_seq_ff, send_seq_in;
   logic          recv_seq_ff, recv_seq_in;
   logic [3:0]    retries_ff, retries_in;
   logic [3:0]    max_retries_ff;

   // Response register
   logic          rsp_valid_ff;
   tx_kind_type   tx_kind_ff, tx_kind_in;
   logic [7:0]    tx_ctrl_ff, tx_ctrl_in;
   logic          deliver_ff, deliver_in;
   logic          give_up_ff, give_up_in;
   timer_cmd_type timer_ff, timer_in;
   logic          refused_ff, refused_in;

   logic          accept;
   logic          is_ack;
   logic          seq;
   op_type        op;

   // Take a request whenever the response slot frees up this cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign op     = op_type'(req_chan.operation);
   assign is_ack = req_chan.frame_ctrl[CTRL_ACK_BIT];
   assign seq    = req_chan.frame_ctrl[CTRL_SEQ_BIT];

   // Next state and result for the presented event
   always_comb begin
      phase_in    = phase_ff;
      send_seq_in = send_seq_ff;
      recv_seq_in = recv_seq_ff;
      retries_in  = retries_ff;
      tx_kind_in  = TX_NONE;
      tx_ctrl_in  = 8'h00;
      deliver_in  = 1'b0;
      give_up_in  = 1'b0;
      timer_in    = TM_KEEP;
      refused_in  = 1'b0;

      priority if (op == OP_SEND) begin
         if (phase_ff == ST_IDLE) begin
            tx_kind_in = TX_DATA;
            tx_ctrl_in = data_ctrl(send_seq_ff);
            timer_in   = TM_ACK;
            retries_in = 4'd0;
            phase_in   = ST_WAIT;
         end else begin
            refused_in = 1'b1;
         end
      end else if (op == OP_FRAME && !is_ack) begin
         // Incoming data frame
         if (seq == recv_seq_ff) begin
            deliver_in  = 1'b1;
            tx_kind_in  = TX_ACK;
            tx_ctrl_in  = ack_ctrl(recv_seq_ff);
            recv_seq_in = !recv_seq_ff;
            if (phase_ff == ST_IDLE)
               timer_in = TM_STOP;
            else if (phase_ff != ST_WAIT)
               timer_in = TM_BACKOFF;
         end else if (phase_ff == ST_IDLE || phase_ff == ST_WAIT) begin
            // Duplicate: re-ack, do not deliver
            tx_kind_in = TX_ACK;
            tx_ctrl_in = ack_ctrl(seq);
            if (phase_ff == ST_IDLE)
               timer_in = TM_STOP;
         end
      end else if (phase_ff == ST_WAIT && op == OP_FRAME && seq == send_seq_ff) begin
         // Matching ack
         send_seq_in = !send_seq_ff;
         retries_in  = 4'd0;
         timer_in    = TM_BACKOFF;
         phase_in    = ST_BACK_ACK;
      end else if (phase_ff == ST_WAIT && (op == OP_FRAME || op == OP_TIMER)) begin
         // Wrong ack or ack timeout
         if (retries_ff >= max_retries_ff) begin
            give_up_in = 1'b1;
            retries_in = 4'd0;
            timer_in   = TM_STOP;
            phase_in   = ST_IDLE;
         end else begin
            retries_in = retries_ff + 4'd1;
            timer_in   = TM_BACKOFF;
            phase_in   = ST_BACK_RTX;
         end
      end else if (op == OP_TIMER && phase_ff == ST_BACK_ACK) begin
         timer_in = TM_STOP;
         phase_in = ST_IDLE;
      end else if (op == OP_TIMER && phase_ff == ST_BACK_RTX) begin
         tx_kind_in = TX_RTX;
         tx_ctrl_in = data_ctrl(send_seq_ff);
         timer_in   = TM_ACK;
         phase_in   = ST_WAIT;
      end else begin
         // Ignored event: all-zero result
      end
   end

   // State, config register and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= ST_IDLE;
         send_seq_ff    <= 1'b0;
         recv_seq_ff    <= 1'b0;
         retries_ff     <= 4'd0;
         max_retries_ff <= MAX_RETRIES_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en)
            max_retries_ff <= csr_wr_data;
         if (accept) begin
            phase_ff     <= phase_in;
            send_seq_ff  <= send_seq_in;
            recv_seq_ff  <= recv_seq_in;
            retries_ff   <= retries_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload, loaded on accept only
   always_ff @(posedge clock) begin
      if (accept) begin
         tx_kind_ff <= tx_kind_in;
         tx_ctrl_ff <= tx_ctrl_in;
         deliver_ff <= deliver_in;
         give_up_ff <= give_up_in;
         timer_ff   <= timer_in;
         refused_ff <= refused_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.tx_kind         = tx_kind_ff;
   assign rsp_chan.tx_ctrl         = tx_ctrl_ff;
   assign rsp_chan.deliver_up      = deliver_ff;
   assign rsp_chan.give_up         = give_up_ff;
   assign rsp_chan.timer_cmd       = timer_ff;
   assign rsp_chan.request_refused = refused_ff;
   assign rsp_chan.phase_now       = phase_ff;

   // A waiting response blocks intake unless it drains this cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request accepted over an undrained response");

   // Giving up always lands in idle with the timer stopped
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && give_up_ff |-> phase_ff == ST_IDLE && timer_ff == TM_STOP)
      else $error("give_up without return to idle");

   // A delivery is always acknowledged
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && deliver_ff |-> tx_kind_ff == TX_ACK)
      else $error("delivery without ack");

   // A retransmit is followed by waiting for the ack
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && tx_kind_ff == TX_RTX |-> phase_ff == ST_WAIT && timer_ff == TM_ACK)
      else $error("retransmit without ack timeout");

   // Phase only moves on an accepted request
   assert property (@(posedge clock) disable iff (reset)
      !$past(accept) && !$past(reset) |-> $stable(phase_ff))
      else $error("phase changed without a request");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Testbench for stop_and_wait_arq_fsm: directed request table, then random
// event traffic under several retry limits, checked against a local predictor.
// Depends on saw_pkg, saw_req_if, saw_rsp_if and the controller RTL.
module tb;
   import saw_pkg::*;

   // Fourth event code, ignored by the controller in every phase
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int LIMIT_CYCLES    = 400000;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int DIRECTED_COUNT  = 25;
   localparam int MAX_REPORTS     = 10;

   typedef struct packed {
      tx_kind_type   kind;
      logic [7:0]    ctrl;
      logic          deliver;
      logic          give_up;
      timer_cmd_type timer;
      logic          refused;
      logic [1:0]    phase;
   } arq_outcome_type;

   typedef struct packed {
      logic            typed;
      arq_outcome_type outcome;
   } pin_entry_type;

   typedef struct packed {
      logic [1:0]      op;
      logic [7:0]      ctrl;
      logic            typed;
      arq_outcome_type outcome;
   } directed_row_type;

   typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_type;

   localparam arq_outcome_type QUIET_IDLE =
      '{TX_NONE, 8'h00, 1'b0, 1'b0, TM_KEEP, 1'b0, PHASE_IDLE};

   // Walk through every phase with the reset retry limit; typed rows carry
   // the obvious answer, the rest go through the predictor.
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{OP_UNUSED, 8'hFF, 1'b1, QUIET_IDLE},
      '{OP_TIMER,  8'h00, 1'b1, QUIET_IDLE},
      '{OP_FRAME,  8'h80, 1'b1, QUIET_IDLE},
      '{OP_FRAME,  8'h08, 1'b1,
        '{TX_ACK, CTRL_ACK1, 1'b0, 1'b0, TM_STOP, 1'b0, PHASE_IDLE}},
      '{OP_FRAME,  8'h77, 1'b1,
        '{TX_ACK, CTRL_ACK0, 1'b1, 1'b0, TM_STOP, 1'b0, PHASE_IDLE}},
      '{OP_SEND,   8'hFF, 1'b1,
        '{TX_DATA, CTRL_DATA0, 1'b0, 1'b0, TM_ACK, 1'b0, PHASE_WAIT}},
      '{OP_SEND,   8'h00, 1'b1,
        '{TX_NONE, 8'h00, 1'b0, 1'b0, TM_KEEP, 1'b1, PHASE_WAIT}},
      '{OP_UNUSED, 8'h08, 1'b0, QUIET_IDLE},
      '{OP_FRAME,  8'h00, 1'b0, QUIET_IDLE},
      '{OP_FRAME,  8'h08, 1'b0, QUIET_IDLE},
      '{OP_FRAME,  8'h88, 1'b0, QUIET_IDLE},
      '{OP_FRAME,  8'h00, 1'b0, QUIET_IDLE},
      '{OP_FRAME,  8'h00, 1'b0, QUIET_IDLE},
      '{OP_FRAME,  8'h80, 1'b0, QUIET_IDLE},
      '{OP_SEND,   8'h00, 1'b0, QUIET_IDLE},
      '{OP_TIMER,  8'hFF, 1'b0, QUIET_IDLE},
      '{OP_TIMER,  8'h00, 1'b0, QUIET_IDLE},
      '{OP_TIMER,  8'h00, 1'b0, QUIET_IDLE},
      '{OP_TIMER,  8'h00, 1'b0, QUIET_IDLE},
      '{OP_TIMER,  8'h00, 1'b0, QUIET_IDLE},
      '{OP_TIMER,  8'h00, 1'b1,
        '{TX_NONE, 8'h00, 1'b0, 1'b1, TM_STOP, 1'b0, PHASE_IDLE}},
      '{OP_SEND,   8'h00, 1'b0, QUIET_IDLE},
      '{OP_FRAME,  8'h80, 1'b0, QUIET_IDLE},
      '{OP_FRAME,  8'h08, 1'b0, QUIET_IDLE},
      '{OP_TIMER,  8'h00, 1'b0, QUIET_IDLE}
   };

   logic clock;
   logic reset;
   logic       csr_wr_en;
   logic [3:0] csr_wr_data;

   saw_req_if req_chan ();
   saw_rsp_if rsp_chan ();

   stop_and_wait_arq_fsm dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Predictor state
   logic [1:0] arq_phase;
   logic       tx_seq;
   logic       rx_seq;
   logic [3:0] retry_count;
   logic [3:0] retry_limit;

   arq_outcome_type pending_outcomes [$];
   pin_entry_type   typed_outcomes [$];

   int requests_accepted = 0;
   int results_seen      = 0;
   int error_count       = 0;
   int cycle_count       = 0;

   rx_pattern_type rx_pattern;
   int             rx_left;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // One protocol step: updates the predictor state, returns the response
   function automatic arq_outcome_type predict_arq_step(input logic [1:0] op,
                                                        input logic [7:0] ctrl);
      arq_outcome_type o;
      logic            is_ack;
      logic            seq;
      o      = QUIET_IDLE;
      is_ack = ctrl[CTRL_ACK_BIT];
      seq    = ctrl[CTRL_SEQ_BIT];
      if (op == OP_SEND) begin
         if (arq_phase == PHASE_IDLE) begin
            o.kind      = TX_DATA;
            o.ctrl      = tx_seq ? CTRL_DATA1 : CTRL_DATA0;
            o.timer     = TM_ACK;
            retry_count = 4'd0;
            arq_phase   = PHASE_WAIT;
         end else begin
            o.refused = 1'b1;
         end
      end else if (op == OP_FRAME && !is_ack) begin
         // data frame: in-sequence goes up, duplicates acked only when not backing off
         if (seq == rx_seq) begin
            o.deliver = 1'b1;
            o.kind    = TX_ACK;
            o.ctrl    = rx_seq ? CTRL_ACK1 : CTRL_ACK0;
            rx_seq    = ~rx_seq;
            if (arq_phase == PHASE_IDLE)
               o.timer = TM_STOP;
            else if (arq_phase != PHASE_WAIT)
               o.timer = TM_BACKOFF;
         end else if (arq_phase == PHASE_IDLE || arq_phase == PHASE_WAIT) begin
            o.kind = TX_ACK;
            o.ctrl = seq ? CTRL_ACK1 : CTRL_ACK0;
            if (arq_phase == PHASE_IDLE)
               o.timer = TM_STOP;
         end
      end else if (arq_phase == PHASE_WAIT && op == OP_FRAME && seq == tx_seq) begin
         tx_seq      = ~tx_seq;
         retry_count = 4'd0;
         o.timer     = TM_BACKOFF;
         arq_phase   = PHASE_BACK_ACK;
      end else if (arq_phase == PHASE_WAIT && (op == OP_FRAME || op == OP_TIMER)) begin
         // wrong ack or timeout
         if (retry_count >= retry_limit) begin
            o.give_up   = 1'b1;
            retry_count = 4'd0;
            o.timer     = TM_STOP;
            arq_phase   = PHASE_IDLE;
         end else begin
            retry_count = retry_count + 4'd1;
            o.timer     = TM_BACKOFF;
            arq_phase   = PHASE_BACK_RTX;
         end
      end else if (op == OP_TIMER && arq_phase == PHASE_BACK_ACK) begin
         o.timer   = TM_STOP;
         arq_phase = PHASE_IDLE;
      end else if (op == OP_TIMER && arq_phase == PHASE_BACK_RTX) begin
         o.kind    = TX_RTX;
         o.ctrl    = tx_seq ? CTRL_DATA1 : CTRL_DATA0;
         o.timer   = TM_ACK;
         arq_phase = PHASE_WAIT;
      end
      o.phase = arq_phase;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input arq_outcome_type want,
                                  input arq_outcome_type got);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("cycle %0d %s: exp kind=%0d ctrl=%h dlv=%b gup=%b tmr=%0d ref=%b ph=%0d",
                  cycle_count, what, want.kind, want.ctrl, want.deliver, want.give_up,
                  want.timer, want.refused, want.phase);
         $display("   got kind=%0d ctrl=%h dlv=%b gup=%b tmr=%0d ref=%b ph=%0d",
                  got.kind, got.ctrl, got.deliver, got.give_up, got.timer,
                  got.refused, got.phase);
      end
   endtask

   // Predict on each accepted request, check each accepted response
   arq_outcome_type observed;
   arq_outcome_type wanted;
   pin_entry_type   pin;

   always @(posedge clock) begin
      if (reset) begin
         arq_phase   = PHASE_IDLE;
         tx_seq      = 1'b0;
         rx_seq      = 1'b0;
         retry_count = 4'd0;
         retry_limit = MAX_RETRIES_RESET;
      end else begin
         if (csr_wr_en)
            retry_limit = csr_wr_data;
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) begin
            pin    = typed_outcomes.pop_front();
            wanted = predict_arq_step(req_chan.operation, req_chan.frame_ctrl);
            pending_outcomes.push_back(pin.typed ? pin.outcome : wanted);
         end
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            observed.kind    = tx_kind_type'(rsp_chan.tx_kind);
            observed.ctrl    = rsp_chan.tx_ctrl;
            observed.deliver = rsp_chan.deliver_up;
            observed.give_up = rsp_chan.give_up;
            observed.timer   = timer_cmd_type'(rsp_chan.timer_cmd);
            observed.refused = rsp_chan.request_refused;
            observed.phase   = rsp_chan.phase_now;
            results_seen++;
            if (pending_outcomes.size() == 0) begin
               report_mismatch("unexpected response", QUIET_IDLE, observed);
            end else begin
               wanted = pending_outcomes.pop_front();
               if (observed !== wanted)
                  report_mismatch("mismatch", wanted, observed);
            end
         end
      end
   end

   // Receiver: switches between backpressure patterns chosen at random
   always @(posedge clock) begin
      if (reset) begin
         rx_pattern     <= RX_STREAM;
         rx_left        <= 0;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_pattern <= rx_pattern_type'($urandom_range(0, 3));
            rx_left    <= $urandom_range(8, 80);
         end else begin
            rx_left <= rx_left - 1;
         end
         case (rx_pattern)
            RX_STREAM: rsp_chan.ready <= 1'b1;
            RX_COIN:   rsp_chan.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_chan.ready <= (rx_left % 4 != 0);
         endcase
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Drive one request and hold it until the controller takes it
   task automatic send_request(input logic [1:0] op, input logic [7:0] ctrl,
                               input logic typed, input arq_outcome_type outcome);
      pin_entry_type entry;
      entry.typed   = typed;
      entry.outcome = outcome;
      typed_outcomes.push_back(entry);
      req_chan.valid      <= 1'b1;
      req_chan.operation  <= op;
      req_chan.frame_ctrl <= ctrl;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      requests_accepted++;
   endtask

   task automatic await_drain();
      while (results_seen != requests_accepted)
         @(posedge clock);
   endtask

   // Retry limit may only change while nothing is in flight
   task automatic set_retry_limit(input logic [3:0] limit);
      await_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      int         p;
      int         k;
      int         burst;
      int         gap;
      int         remaining;
      int         pick;
      bit         storm;
      logic [1:0] op;
      logic [7:0] ctrl;
      logic [3:0] limit;

      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = 4'd0;
      req_chan.valid      = 1'b0;
      req_chan.operation  = OP_SEND;
      req_chan.frame_ctrl = 8'h00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, reset retry limit
      for (k = 0; k < DIRECTED_COUNT; k++)
         send_request(DIRECTED_ROWS[k].op, DIRECTED_ROWS[k].ctrl,
                      DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].outcome);
      req_chan.valid <= 1'b0;

      // Random traffic, one retry limit per phase
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       limit = 4'd0;
            1:       limit = 4'd15;
            2:       limit = 4'd1;
            4:       limit = 4'd15;
            default: limit = 4'($urandom_range(0, 15));
         endcase
         set_retry_limit(limit);
         remaining = ITEMS_PER_PHASE;
         while (remaining > 0) begin
            burst = $urandom_range(1, 24);
            // timer storms push the retry count up to the limit
            storm = ($urandom_range(0, 4) == 0);
            for (k = 0; k < burst && remaining > 0; k++) begin
               pick = $urandom_range(0, 99);
               if (storm)
                  op = (pick < 85) ? OP_TIMER : ((pick < 95) ? OP_FRAME : OP_SEND);
               else if (pick < 25)
                  op = OP_SEND;
               else if (pick < 65)
                  op = OP_FRAME;
               else if (pick < 95)
                  op = OP_TIMER;
               else
                  op = OP_UNUSED;
               ctrl = 8'($urandom_range(0, 255));
               send_request(op, ctrl, 1'b0, QUIET_IDLE);
               remaining--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0 || remaining == 0) begin
               req_chan.valid <= 1'b0;
               repeat (gap) @(posedge clock);
               if ($urandom_range(0, 19) == 0)
                  await_drain();
            end
         end
      end

      await_drain();
      repeat (4) @(posedge clock);
      if (error_count == 0 && pending_outcomes.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
